/* sv/mma_pkg.sv */
// shared constants, types and status decoding for the midi message assembler
`default_nettype none
package mma_pkg;

  localparam int unsigned MSG_BUFFER_DEPTH = 64;
  localparam int unsigned ADDR_W = $clog2(MSG_BUFFER_DEPTH);
  localparam int unsigned CNT_W  = $clog2(MSG_BUFFER_DEPTH + 1);

  localparam logic [7:0] SYSEX_START  = 8'hf0;
  localparam logic [7:0] SYSEX_END    = 8'hf7;
  localparam logic [7:0] REALTIME_MIN = 8'hf8;
  localparam logic [7:0] STATUS_FLAG  = 8'h80;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // emission request from the decoder to the sequencer
  typedef struct packed {
    logic       imm;      // one-byte message straight from the input
    logic [7:0] imm_byte;
    logic       mem;      // message held in the buffer
    cnt_t       len;      // number of buffered bytes to send
  } emit_req_t;

  // standard message length of a status byte, zero for none or sysex
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd0;
    if ((s & STATUS_FLAG) == 8'h00) begin
      len = 2'd0;
    end else if (s < 8'hc0) begin
      len = 2'd3;
    end else if (s < 8'he0) begin
      len = 2'd2;
    end else if (s < SYSEX_START) begin
      len = 2'd3;
    end else if (s >= REALTIME_MIN) begin
      len = 2'd1;
    end else begin
      unique case (s[3:0])
        4'h1:    len = 2'd2;
        4'h2:    len = 2'd3;
        4'h3:    len = 2'd2;
        4'h6:    len = 2'd1;
        default: len = 2'd0;
      endcase
    end
    return len;
  endfunction

endpackage
`default_nettype wire

/* sv/mma_ram.sv */
// single-port-write, single-port-read buffer ram with registered read data
`default_nettype none
module mma_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* sv/mma_ctrl.sv */
// byte decoder: pending count, status shadow, buffer writes and emit requests
`default_nettype none
module mma_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               running_en_i,
  output logic                    we_o,
  output mma_pkg::addr_t          waddr_o,
  output mma_pkg::emit_req_t      req_o
);
  import mma_pkg::*;

  cnt_t       cnt_q, cnt_d;
  logic [7:0] st_q, st_d;
  logic [1:0] len_b, len_st;
  logic       interrupt;
  cnt_t       cnt_next;
  logic       complete;

  always_comb begin
    len_b     = msg_len(in_byte_i);
    len_st    = msg_len(st_q);
    interrupt = (cnt_q != '0) && in_byte_i[7]
                && !((st_q == SYSEX_START) && (in_byte_i == SYSEX_END));
    cnt_next  = cnt_q + CNT_W'(1);
    complete  = (st_q == SYSEX_START) ? (in_byte_i == SYSEX_END)
                                      : (cnt_next == CNT_W'(len_st));
    cnt_d   = cnt_q;
    st_d    = st_q;
    we_o    = 1'b0;
    waddr_o = '0;
    req_o   = '0;
    if (accept_i) begin
      if (in_byte_i >= REALTIME_MIN) begin
        // real-time byte leaves the pending message alone
        req_o.imm      = 1'b1;
        req_o.imm_byte = in_byte_i;
      end else if ((cnt_q == '0) || interrupt) begin
        if ((len_b != 2'd0) || (in_byte_i == SYSEX_START)) begin
          we_o = 1'b1;
          st_d = in_byte_i;
          if (len_b == 2'd1) begin
            // tune request goes out at once
            req_o.imm      = 1'b1;
            req_o.imm_byte = in_byte_i;
            cnt_d          = '0;
          end else begin
            cnt_d = CNT_W'(1);
          end
        end else begin
          cnt_d = '0;
        end
      end else if (cnt_q == CNT_W'(MSG_BUFFER_DEPTH)) begin
        // sysex overflow, dropped quietly
        cnt_d = '0;
      end else begin
        we_o    = 1'b1;
        waddr_o = cnt_q[ADDR_W-1:0];
        if (complete) begin
          req_o.mem = 1'b1;
          req_o.len = cnt_next;
          cnt_d     = (running_en_i && (st_q < SYSEX_START)) ? CNT_W'(1) : '0;
        end else begin
          cnt_d = cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // shadow of buffer entry zero
  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MSG_BUFFER_DEPTH))
    else $error("pending count beyond buffer depth");

endmodule
`default_nettype wire

/* sv/mma_emit.sv */
// emit sequencer: streams buffered bytes or a single byte to the output
`default_nettype none
module mma_emit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mma_pkg::emit_req_t req_i,
  input  wire logic [7:0]         rd_data_i,
  output logic                    rd_en_o,
  output mma_pkg::addr_t          rd_addr_o,
  output logic                    busy_o,
  output logic                    msg_valid_o,
  input  wire logic               msg_stall_i,
  output logic [7:0]              msg_byte_o,
  output logic                    msg_last_o
);
  import mma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } emit_state_e;

  emit_state_e state_q, state_d;
  cnt_t        idx_q, idx_d;
  cnt_t        len_q, len_d;
  logic        out_valid_q, out_valid_d;
  logic        last_q, last_d;
  logic        direct_q, direct_d;
  logic [7:0]  imm_q, imm_d;
  logic        taken;
  logic        rd_last;

  assign taken   = out_valid_q && !msg_stall_i;
  assign rd_last = (CNT_W'(idx_q + CNT_W'(1)) == len_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    direct_d    = direct_q;
    imm_d       = imm_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q[ADDR_W-1:0];
    if (taken) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.imm) begin
          out_valid_d = 1'b1;
          direct_d    = 1'b1;
          imm_d       = req_i.imm_byte;
          last_d      = 1'b1;
        end else if (req_i.mem) begin
          state_d = ST_EMIT;
          idx_d   = '0;
          len_d   = req_i.len;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || taken) begin
          rd_en_o     = 1'b1;
          out_valid_d = 1'b1;
          direct_d    = 1'b0;
          last_d      = rd_last;
          idx_d       = CNT_W'(idx_q + CNT_W'(1));
          if (rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    len_q    <= len_d;
    last_q   <= last_d;
    direct_q <= direct_d;
    imm_q    <= imm_d;
  end

  assign busy_o      = (state_q != ST_IDLE) || out_valid_q;
  assign msg_valid_o = out_valid_q;
  assign msg_byte_o  = direct_q ? imm_q : rd_data_i;
  assign msg_last_o  = last_q;

  a_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.imm || req_i.mem) |-> (state_q == ST_IDLE) && !out_valid_q)
    else $error("emit request while busy");

  a_req_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.imm && req_i.mem))
    else $error("both emit requests at once");

  a_read_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> out_valid_q && !direct_q)
    else $error("buffer read not presented");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (len_q != '0) && (idx_q < len_q))
    else $error("emit index out of range");

endmodule
`default_nettype wire

/* sv/midi_message_assembler_top.sv */
// midi message assembler top level: config register, decoder, buffer and emitter
// a real-time or tune request item shows on the output in the cycle after it is taken
// a completed buffered message shows its first byte once the emitter is in its emit state
// and has read it into the ram read register, then streams one byte per cycle from the
// buffer ram read port while the output is not stalled; an item with no result does not
// stall the input, one that yields a message holds it stalled until its final byte is taken
// reset clears the pending count, emitter state and config; the buffer ram is not cleared
`default_nettype none
module midi_message_assembler_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration write
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // byte input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  // message output channel
  output logic            msg_valid_o,
  input  wire logic       msg_stall_i,
  output logic [7:0]      msg_byte_o,
  output logic            msg_last_o
);
  import mma_pkg::*;

  // running status enable register
  logic rse_q, rse_d;

  logic      accept;
  logic      busy;
  logic      we;
  addr_t     waddr;
  emit_req_t req;
  logic      rd_en;
  addr_t     rd_addr;
  logic [7:0] rd_data;

  assign rse_d = cfg_we_i ? cfg_wdata_i : rse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rse_q <= 1'b0;
    end else begin
      rse_q <= rse_d;
    end
  end

  // one item at a time: stall while a message is in flight or the output holds a byte,
  // so buffer writes and emit reads never touch the ram in the same cycle
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  // decode each item against the pending count and status
  mma_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_byte_i),
    .running_en_i (rse_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .req_o        (req)
  );

  // pending message bytes
  mma_ram #(
    .DEPTH (MSG_BUFFER_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // stream the finished message out, the ram read register doubles as output register
  mma_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rd_data_i   (rd_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .busy_o      (busy),
    .msg_valid_o (msg_valid_o),
    .msg_stall_i (msg_stall_i),
    .msg_byte_o  (msg_byte_o),
    .msg_last_o  (msg_last_o)
  );

endmodule
`default_nettype wire
